>>> src/dtli_pkg.sv
// Shared types and codes for the dual table linear interpolator.
`timescale 1ns / 1ps
package dtli_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_PHOTO   = 2'd0,
    CMD_LOAD_COMPTON = 2'd1,
    CMD_QUERY        = 2'd2,
    CMD_NONE         = 2'd3
  } cmd_t;

  // Register index as decoded from paddr[2].
  localparam logic REG_PHOTO_USED   = 1'b0;
  localparam logic REG_COMPTON_USED = 1'b1;

  localparam logic [7:0] PHOTO_USED_RESET   = 8'd91;
  localparam logic [6:0] COMPTON_USED_RESET = 7'd64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LOAD0,
    S_CMP,
    S_MULA,
    S_MULB,
    S_ADD,
    S_DIV,
    S_STORE,
    S_NEXT,
    S_DONE
  } state_t;

endpackage

>>> src/dual_table_linear_interpolator.sv
// Dual breakpoint table interpolator: two table memories, scan sequencer, serial divider.
// Usage: load breakpoints with start/in_cmd 0 (photo) or 1 (Compton), one word per
// cycle while busy is low; loads give no result. A query (in_cmd 2) scans the photo
// table, then the Compton table, one segment per cycle from a registered-read memory.
// On a hit, one shared 32x32 multiplier forms both products in turn and a restoring
// divider forms a 64-bit quotient, one quotient bit a cycle. busy stays high through
// the strobe cycle and falls the cycle after; the next word is taken once busy falls.
// The result word is valid with out_strobe, a one-cycle strobe, and stays held after
// it; the receiver cannot stall, so it must take it then. A table with no matching
// segment repeats its last interpolated value with its found flag clear. cmd 3 is
// accepted and dropped. Points in use are set over the APB port: offset 0 photo,
// offset 4 Compton; write them only while busy is low. Reset clears the held values
// to zero, sets the points in use to 91 and 64 and leaves table contents undefined
// until loaded.
`timescale 1ns / 1ps
module dual_table_linear_interpolator
  import dtli_pkg::*;
#(
  parameter int PHOTO_DEPTH   = 128,
  parameter int COMPTON_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [6:0]  in_point_index,
  input  logic [31:0] in_energy,
  input  logic [31:0] in_point_sigma,
  output logic        out_strobe,
  output logic [31:0] out_photo_xs,
  output logic [31:0] out_compton_xs,
  output logic        out_photo_found,
  output logic        out_compton_found,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PAW  = (PHOTO_DEPTH > 1) ? $clog2(PHOTO_DEPTH) : 1;
  localparam int CAW  = (COMPTON_DEPTH > 1) ? $clog2(COMPTON_DEPTH) : 1;
  localparam int MAXD = (PHOTO_DEPTH > COMPTON_DEPTH) ? PHOTO_DEPTH : COMPTON_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);

  state_t state_r, state_nxt;

  logic [7:0]  photo_used_r;
  logic [6:0]  compton_used_r;
  logic        tsel_r;
  logic [31:0] e_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_photo, n_compton, n_sel;

  logic [63:0] photo_mem [PHOTO_DEPTH];
  logic [63:0] compton_mem [COMPTON_DEPTH];
  logic [63:0] p_rd_r, c_rd_r, rd;

  logic [63:0] prev_r;
  logic [31:0] y0_r, y1_r, d0_r, d1_r, den_r;
  logic [63:0] prod_r, acc_r;
  logic [64:0] sum;
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [32:0] rem_sh;
  logic [5:0]  div_cnt_r;
  logic [31:0] held_photo_r, held_compton_r;
  logic        pf_r, cf_r;
  logic [31:0] mul_a, mul_b;
  logic [31:0] q_sat;
  logic        hit, last_seg, accept, cfg_wr;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_PHOTO_USED:   prdata = {24'd0, photo_used_r};
      REG_COMPTON_USED: prdata = {25'd0, compton_used_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      photo_used_r   <= PHOTO_USED_RESET;
      compton_used_r <= COMPTON_USED_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PHOTO_USED:   photo_used_r   <= pwdata[7:0];
        REG_COMPTON_USED: compton_used_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Clamp points in use to the table depth.
  assign n_photo   = (int'(photo_used_r) > PHOTO_DEPTH) ? CW'(PHOTO_DEPTH)
                                                        : CW'(photo_used_r);
  assign n_compton = (int'(compton_used_r) > COMPTON_DEPTH) ? CW'(COMPTON_DEPTH)
                                                            : CW'(compton_used_r);
  assign n_sel     = tsel_r ? n_compton : n_photo;

  // Table memories: written by loads while idle, read during the scan.
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD_PHOTO && int'(in_point_index) < PHOTO_DEPTH)
      photo_mem[PAW'(in_point_index)] <= {in_energy, in_point_sigma};
    p_rd_r <= photo_mem[cnt_nxt[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD_COMPTON && int'(in_point_index) < COMPTON_DEPTH)
      compton_mem[CAW'(in_point_index)] <= {in_energy, in_point_sigma};
    c_rd_r <= compton_mem[cnt_nxt[CAW-1:0]];
  end

  assign rd       = tsel_r ? c_rd_r : p_rd_r;
  assign hit      = (e_r >= prev_r[63:32]) && (e_r < rd[63:32]);
  assign last_seg = (cnt_r == n_sel - CW'(1));
  assign rem_sh   = {rem_r, quo_r[63]};
  assign sum      = {1'b0, acc_r} + {1'b0, prod_r};
  assign q_sat    = (quo_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_r[31:0];
  assign mul_a    = (state_r == S_MULA) ? y0_r : y1_r;
  assign mul_b    = (state_r == S_MULA) ? d0_r : d1_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_cmd == CMD_QUERY) state_nxt = S_START;
      S_START: state_nxt = (n_sel < CW'(2)) ? S_NEXT : S_LOAD0;
      S_LOAD0: state_nxt = S_CMP;
      S_CMP: begin
        if (hit) state_nxt = S_MULA;
        else if (last_seg) state_nxt = S_NEXT;
      end
      S_MULA:  state_nxt = S_MULB;
      S_MULB:  state_nxt = S_ADD;
      S_ADD:   state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == 6'd63) state_nxt = S_STORE;
      S_STORE: state_nxt = S_NEXT;
      S_NEXT:  state_nxt = tsel_r ? S_DONE : S_START;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_START: cnt_nxt = '0;
      S_LOAD0: cnt_nxt = CW'(1);
      S_CMP:   if (!hit && !last_seg) cnt_nxt = cnt_r + CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tsel_r         <= 1'b0;
      cnt_r          <= '0;
      held_photo_r   <= 32'd0;
      held_compton_r <= 32'd0;
      pf_r           <= 1'b0;
      cf_r           <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      unique case (state_r)
        S_IDLE: begin
          tsel_r <= 1'b0;
          if (accept) begin
            pf_r <= 1'b0;
            cf_r <= 1'b0;
          end
        end
        S_STORE: begin
          if (tsel_r) begin
            held_compton_r <= q_sat;
            cf_r           <= 1'b1;
          end else begin
            held_photo_r <= q_sat;
            pf_r         <= 1'b1;
          end
        end
        S_NEXT:  tsel_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath: segment operands, shared multiplier, restoring divider.
  always_ff @(posedge clk) begin
    if (accept) e_r <= in_energy;
    if (state_r == S_LOAD0 || state_r == S_CMP) prev_r <= rd;
    if (state_r == S_CMP) begin
      y0_r  <= prev_r[31:0];
      y1_r  <= rd[31:0];
      d0_r  <= rd[63:32] - e_r;
      d1_r  <= e_r - prev_r[63:32];
      den_r <= rd[63:32] - prev_r[63:32];
    end
    if (state_r == S_MULA || state_r == S_MULB) prod_r <= mul_a * mul_b;
    if (state_r == S_MULB) acc_r <= prod_r;
    if (state_r == S_ADD) begin
      quo_r     <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      rem_r     <= 32'd0;
      div_cnt_r <= 6'd0;
    end
    if (state_r == S_DIV) begin
      div_cnt_r <= div_cnt_r + 6'd1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, den_r});
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  assign out_photo_xs      = held_photo_r;
  assign out_compton_xs    = held_compton_r;
  assign out_photo_found   = pf_r;
  assign out_compton_found = cf_r;

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_QUERY) |=> busy)
    else $error("query accepted but block not busy");
  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("block still busy after result strobe");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != 32'd0))
    else $error("divider running with zero divisor");
`endif

endmodule
